// File: hdl/temp_sensor_supervisor_filter_defines.svh
// Assertion macros shared by the temperature supervisor RTL.
`ifndef TEMP_SENSOR_SUPERVISOR_FILTER_DEFINES_SVH
`define TEMP_SENSOR_SUPERVISOR_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TSSF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TSSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tssf_pkg.sv
// Shared types and constants of the temperature supervisor.
package tssf_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MEDIAN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TMIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TMAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER = 3'd5;

    localparam int ALPHA_W = 17;
    localparam logic [ALPHA_W-1:0] ALPHA_RST    = 17'd6554;
    localparam logic [ALPHA_W-1:0] ALPHA_MIN    = 17'd66;
    localparam logic [ALPHA_W-1:0] ALPHA_BYPASS = 17'd65470;

    localparam logic OP_READING = 1'b0;
    localparam logic OP_FAULT   = 1'b1;

    localparam logic [1:0] REASON_NONE  = 2'd0;
    localparam logic [1:0] REASON_FAULT = 2'd1;
    localparam logic [1:0] REASON_RANGE = 2'd2;

    localparam logic [7:0] STREAK_MAX  = 8'd255;
    localparam logic [7:0] RECOVER_RST = 8'd3;

    // Median history bookkeeping: write pointer and fill level.
    typedef struct packed {
        logic [1:0] head;
        logic [1:0] count;
    } t_hist_ctl;

endpackage

// File: hdl/tssf_median.sv
// Median-of-three front end: history write, mean of two, median of three.
module tssf_median #(
    parameter int TW = 24
) (
    input  logic                     i_en,
    input  logic signed [TW-1:0]     i_x,
    input  logic signed [TW-1:0]     i_hist [3],
    input  tssf_pkg::t_hist_ctl      i_ctl,
    output logic signed [TW-1:0]     o_f,
    output logic signed [TW-1:0]     o_hist [3],
    output tssf_pkg::t_hist_ctl      o_ctl
);

    logic signed [TW:0]   sum2;
    logic signed [TW-1:0] lo_ab;
    logic signed [TW-1:0] hi_ab;
    logic signed [TW-1:0] mid;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_hist[k] = (i_en && (i_ctl.head == 2'(k))) ? i_x : i_hist[k];
        end
        o_ctl = i_ctl;
        if (i_en) begin
            o_ctl.head  = (i_ctl.head == 2'd2) ? 2'd0 : i_ctl.head + 2'd1;
            o_ctl.count = (i_ctl.count == 2'd3) ? 2'd3 : i_ctl.count + 2'd1;
        end
    end

    // Floor of the mean: sign-extend, add, drop the low bit.
    assign sum2  = {o_hist[0][TW-1], o_hist[0]} + {o_hist[1][TW-1], o_hist[1]};
    assign lo_ab = (o_hist[0] <= o_hist[1]) ? o_hist[0] : o_hist[1];
    assign hi_ab = (o_hist[0] <= o_hist[1]) ? o_hist[1] : o_hist[0];
    assign mid   = (hi_ab <= o_hist[2]) ? hi_ab :
                   ((lo_ab >= o_hist[2]) ? lo_ab : o_hist[2]);

    always_comb begin
        o_f = i_x;
        if (i_en) begin
            case (o_ctl.count)
                2'd2:    o_f = sum2[TW:1];
                2'd3:    o_f = mid;
                default: o_f = i_x;
            endcase
        end
    end

endmodule

// File: hdl/tssf_ema.sv
// Exponential average step with Q0.16 weight and bypass.
module tssf_ema #(
    parameter int TW = 24
) (
    input  logic [tssf_pkg::ALPHA_W-1:0] i_alpha,
    input  logic                         i_valid,
    input  logic signed [TW-1:0]         i_value,
    input  logic signed [TW-1:0]         i_f,
    output logic signed [TW-1:0]         o_value
);

    logic               bypass;
    logic [15:0]        alpha_c;
    logic signed [TW:0]    diff;
    logic signed [TW+17:0] prod;
    logic signed [TW+17:0] rnd;
    logic signed [TW+1:0]  step;
    logic signed [TW+1:0]  sum;

    // Weights at the bypass level or above never reach the multiplier,
    // so sixteen bits hold every weight that does.
    assign bypass  = !i_valid || (i_alpha >= tssf_pkg::ALPHA_BYPASS);
    assign alpha_c = (i_alpha < tssf_pkg::ALPHA_MIN) ? tssf_pkg::ALPHA_MIN[15:0]
                                                     : i_alpha[15:0];

    assign diff = {i_f[TW-1], i_f} - {i_value[TW-1], i_value};
    assign prod = $signed({1'b0, alpha_c}) * diff;
    // Round to nearest, ties upward, then floor-shift by sixteen.
    assign rnd  = prod + (TW+18)'(32768);
    assign step = rnd[TW+17:16];
    assign sum  = {{2{i_value[TW-1]}}, i_value} + step;

    assign o_value = bypass ? i_f : sum[TW-1:0];

endmodule

// File: hdl/temp_sensor_supervisor_filter.sv
// Top level of the temperature sensor supervisor with median and EMA filter.
//
//  channel | direction | beat contents (lowest bit first)
//  --------+-----------+--------------------------------------------------------
//  s       | in        | tuser: op; tdata: temp, temp_valid, fault_status, zero pad
//  m       | out       | tdata: filtered_temp, filtered_valid, reading_ok,
//          |           |        inhibit, fault_reason, fault_streak, last_fault,
//          |           |        zero pad
//  cfg     | in        | write enable, register index, write data
//
// One beat per cycle sustained while the m side takes every result. A beat lands
// in the input register; supervisor, median select and one 16 x (TW+1) multiply
// then load the result register, from which the result is taken.
// The multiply-add of the exponential step sets the cycle.
// Synchronous active-low reset clears control state and restores defaults.
// A stalled output holds its beat; the input register moves on as it is taken.
module temp_sensor_supervisor_filter #(
    parameter int TW = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // slave side
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [0:0]              i_s_tuser,   // op
    // temp, temp_valid, fault_status
    input  logic [((TW + 9 + 7) / 8) * 8 - 1:0] i_s_tdata,
    // master side
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // filtered_temp, filtered_valid, reading_ok, inhibit, fault_reason,
    // fault_streak, last_fault
    output logic [((TW + 21 + 7) / 8) * 8 - 1:0] o_m_tdata,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [tssf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [((TW > tssf_pkg::ALPHA_W) ? TW : tssf_pkg::ALPHA_W) - 1:0] i_cfg_data
);

    localparam int IN_BITS  = TW + 9;
    localparam int IN_DW    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = TW + 21;
    localparam int OUT_DW   = ((OUT_BITS + 7) / 8) * 8;
    localparam int CFG_DW   = (TW > tssf_pkg::ALPHA_W) ? TW : tssf_pkg::ALPHA_W;

    localparam logic signed [TW-1:0] TMIN_RST = TW'(-25600);
    localparam logic signed [TW-1:0] TMAX_RST = TW'(38400);

    // Configuration registers.
    logic                         r_median_en;
    logic [tssf_pkg::ALPHA_W-1:0] r_alpha;
    logic signed [TW-1:0]         r_tmin;
    logic signed [TW-1:0]         r_tmax;
    logic [7:0]                   r_trip;
    logic [7:0]                   r_recover;

    // Input register.
    logic                 r_in_valid;
    logic                 r_in_op;
    logic signed [TW-1:0] r_in_temp;
    logic                 r_in_tvalid;
    logic [7:0]           r_in_code;

    // Supervisor and filter state.
    logic signed [TW-1:0] r_hist [3];
    tssf_pkg::t_hist_ctl  r_hctl,     n_hctl;
    logic signed [TW-1:0] r_fvalue,   n_fvalue;
    logic                 r_fvalid,   n_fvalid;
    logic                 r_ok,       n_ok;
    logic                 r_inhibit,  n_inhibit;
    logic [7:0]           r_good,     n_good;
    logic [7:0]           r_bad,      n_bad;
    logic [7:0]           r_fbyte,    n_fbyte;
    logic [1:0]           r_reason,   n_reason;

    // Result register.
    logic                  r_out_valid;
    logic [OUT_BITS-1:0]   r_out;

    logic                 move;
    logic                 sane;
    logic                 med_en;
    logic [7:0]           bad_inc;
    logic [7:0]           good_inc;
    logic signed [TW-1:0] med_f;
    logic signed [TW-1:0] med_hist [3];
    tssf_pkg::t_hist_ctl  med_ctl;
    logic signed [TW-1:0] ema_value;

    // ---------------------------------------------------------------------
    // Handshake: the input register drains whenever the result slot is free
    // or being emptied in this cycle.
    // ---------------------------------------------------------------------
    assign move       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || move;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DW'(r_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_median_en <= 1'b1;
            r_alpha     <= tssf_pkg::ALPHA_RST;
            r_tmin      <= TMIN_RST;
            r_tmax      <= TMAX_RST;
            r_trip      <= 8'd0;
            r_recover   <= tssf_pkg::RECOVER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tssf_pkg::CFG_MEDIAN:  r_median_en <= i_cfg_data[0];
                tssf_pkg::CFG_ALPHA:   r_alpha     <= i_cfg_data[tssf_pkg::ALPHA_W-1:0];
                tssf_pkg::CFG_TMIN:    r_tmin      <= i_cfg_data[TW-1:0];
                tssf_pkg::CFG_TMAX:    r_tmax      <= i_cfg_data[TW-1:0];
                tssf_pkg::CFG_TRIP:    r_trip      <= i_cfg_data[7:0];
                tssf_pkg::CFG_RECOVER: r_recover   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Capture the accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_op     <= i_s_tuser[0];
            r_in_temp   <= i_s_tdata[TW-1:0];
            r_in_tvalid <= i_s_tdata[TW];
            r_in_code   <= i_s_tdata[TW+8:TW+1];
        end
    end

    // ---------------------------------------------------------------------
    // Datapath: plausibility window, median front end, exponential step.
    // ---------------------------------------------------------------------
    assign sane     = r_in_tvalid && (r_in_temp >= r_tmin) && (r_in_temp <= r_tmax);
    assign med_en   = r_median_en && (r_in_op == tssf_pkg::OP_READING) && sane;
    assign bad_inc  = (r_bad == tssf_pkg::STREAK_MAX) ? r_bad : r_bad + 8'd1;
    assign good_inc = (r_good == tssf_pkg::STREAK_MAX) ? r_good : r_good + 8'd1;

    tssf_median #(.TW(TW)) u_median (
        .i_en   (med_en),
        .i_x    (r_in_temp),
        .i_hist (r_hist),
        .i_ctl  (r_hctl),
        .o_f    (med_f),
        .o_hist (med_hist),
        .o_ctl  (med_ctl)
    );

    tssf_ema #(.TW(TW)) u_ema (
        .i_alpha (r_alpha),
        .i_valid (r_fvalid),
        .i_value (r_fvalue),
        .i_f     (med_f),
        .o_value (ema_value)
    );

    // Supervisor: streaks, inhibit, trip reason and filter clearing.
    always_comb begin
        n_hctl    = r_hctl;
        n_fvalue  = r_fvalue;
        n_fvalid  = r_fvalid;
        n_ok      = r_ok;
        n_inhibit = r_inhibit;
        n_good    = r_good;
        n_bad     = r_bad;
        n_fbyte   = r_fbyte;
        n_reason  = r_reason;
        if (r_in_op == tssf_pkg::OP_FAULT) begin
            n_fbyte = r_in_code;
            n_bad   = bad_inc;
            // Trip on a persistent fault streak unless already inhibited.
            if ((r_trip != 8'd0) && (bad_inc >= r_trip) && !r_inhibit) begin
                n_hctl    = '0;
                n_fvalue  = '0;
                n_fvalid  = 1'b0;
                n_inhibit = 1'b1;
                n_ok      = 1'b0;
                n_good    = 8'd0;
                n_reason  = tssf_pkg::REASON_FAULT;
            end
        end else begin
            n_bad = 8'd0;
            if (!sane) begin
                // Drop the filter; keep the old reason if already inhibited.
                n_ok     = 1'b0;
                n_good   = 8'd0;
                n_hctl   = '0;
                n_fvalue = '0;
                n_fvalid = 1'b0;
                if (!r_inhibit) begin
                    n_inhibit = 1'b1;
                    n_reason  = tssf_pkg::REASON_RANGE;
                end
            end else begin
                n_hctl   = med_ctl;
                n_fvalue = ema_value;
                n_fvalid = 1'b1;
                n_ok     = 1'b1;
                n_good   = good_inc;
                if (r_inhibit && (good_inc >= r_recover)) begin
                    n_inhibit = 1'b0;
                    n_reason  = tssf_pkg::REASON_NONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hctl    <= '0;
            r_fvalue  <= '0;
            r_fvalid  <= 1'b0;
            r_ok      <= 1'b0;
            r_inhibit <= 1'b0;
            r_good    <= 8'd0;
            r_bad     <= 8'd0;
            r_fbyte   <= 8'd0;
            r_reason  <= tssf_pkg::REASON_NONE;
        end else if (move) begin
            r_hctl    <= n_hctl;
            r_fvalue  <= n_fvalue;
            r_fvalid  <= n_fvalid;
            r_ok      <= n_ok;
            r_inhibit <= n_inhibit;
            r_good    <= n_good;
            r_bad     <= n_bad;
            r_fbyte   <= n_fbyte;
            r_reason  <= n_reason;
        end
    end

    // History entries are only read once the fill level covers them.
    always_ff @(posedge i_clk) begin
        if (move) begin
            for (int k = 0; k < 3; k++) begin
                r_hist[k] <= med_hist[k];
            end
        end
    end

    // Result register: hold while stalled, load on every move.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= {n_fbyte, n_bad, n_reason, n_inhibit, n_ok, n_fvalid, n_fvalue};
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
`include "temp_sensor_supervisor_filter_defines.svh"

    `TSSF_ASSERT_NOW(a_inhibit_reason, i_clk, i_rst_n, 1'b1,
        r_inhibit == (r_reason != tssf_pkg::REASON_NONE), "inhibit and reason disagree")
    `TSSF_ASSERT_NOW(a_cleared_filter, i_clk, i_rst_n, !r_fvalid,
        (r_fvalue == '0) && (r_hctl.count == 2'd0), "cleared filter holds stale state")
    `TSSF_ASSERT_NEXT(a_move_gives_beat, i_clk, i_rst_n, move,
        o_m_tvalid, "moved beat did not reach the result register")

endmodule
